// ----- sv/ictf_pkg.sv -----
// Shared types, constants and the CORDIC angle table for the tilt filter.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package ictf_pkg;

    localparam int unsigned WEIGHT_W     = 17;
    localparam logic [16:0] WEIGHT_ONE   = 17'd65536;
    localparam logic [16:0] WEIGHT_RESET = 17'd52429;
    localparam logic signed [25:0] NINETY_DEG = 26'sd5898240;
    localparam int unsigned MAX_STEPS    = 24;
    localparam int unsigned STEP_W       = 5;
    localparam int unsigned SQRT_ITERS   = 24;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [17:0] rate_x;
        logic signed [17:0] rate_y;
        logic signed [17:0] rate_z;
        logic        [19:0] time_step;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_feed;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INC,
        ST_GSUM,
        ST_SQ,
        ST_SUM,
        ST_SQRT,
        ST_CORDIC,
        ST_BMUL,
        ST_BADD,
        ST_OUT
    } t_state;

    // atan(2^-i) in units of 2^-16 degree, rounded.
    function automatic logic signed [25:0] atan_ang(input logic [STEP_W-1:0] idx);
        logic signed [25:0] a;
        case (idx)
            5'd0:    a = 26'sd2949120;
            5'd1:    a = 26'sd1740967;
            5'd2:    a = 26'sd919879;
            5'd3:    a = 26'sd466945;
            5'd4:    a = 26'sd234379;
            5'd5:    a = 26'sd117304;
            5'd6:    a = 26'sd58666;
            5'd7:    a = 26'sd29335;
            5'd8:    a = 26'sd14668;
            5'd9:    a = 26'sd7334;
            5'd10:   a = 26'sd3667;
            5'd11:   a = 26'sd1833;
            5'd12:   a = 26'sd917;
            5'd13:   a = 26'sd458;
            5'd14:   a = 26'sd229;
            5'd15:   a = 26'sd115;
            5'd16:   a = 26'sd57;
            5'd17:   a = 26'sd29;
            5'd18:   a = 26'sd14;
            5'd19:   a = 26'sd7;
            5'd20:   a = 26'sd4;
            5'd21:   a = 26'sd2;
            5'd22:   a = 26'sd1;
            default: a = 26'sd0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// ----- sv/imu_tilt_complementary_filter.sv -----
// IMU tilt complementary filter, top level: weight register, input queue, back end.
// Depends on ictf_pkg, ictf_front and ictf_back.
//
// Usage: a sample beat (accel triple, gyro rate triple, time step) is pushed
// with push while full is low; up to two beats wait in the input queue while
// the back end works. Each beat yields one result beat (roll, pitch, yaw in
// 2^-16 degree), shown while empty is low and taken with pop.
// The back end works one sample at a time: setup and gyro integration, then
// per axis (roll, then pitch) squaring, a bit-serial square root, CORDIC_STEPS
// CORDIC steps and the blend, then the output. Its pace is set by the shared
// square root and CORDIC unit; a zero tilt denominator skips both.
// The gyro weight is written on the cfg channel, which is always ready.
// Reset clears the angles to zero, the weight to 0.8 and empties both sides.
// A stalled receiver holds the result; the back end then waits with the
// next finished result, and the input queue fills and raises full.
`timescale 1ns / 1ps
`default_nettype none
module imu_tilt_complementary_filter #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         push,
    output logic        full,
    input  wire  [15:0] i_accel_x,
    input  wire  [15:0] i_accel_y,
    input  wire  [15:0] i_accel_z,
    input  wire  [17:0] i_rate_x,
    input  wire  [17:0] i_rate_y,
    input  wire  [17:0] i_rate_z,
    input  wire  [19:0] i_time_step,
    output logic        empty,
    input  wire         pop,
    output logic [31:0] o_roll_out,
    output logic [31:0] o_pitch_out,
    output logic [31:0] o_yaw_out,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [16:0] i_cfg_data
);

    logic [16:0] r_weight;
    logic [16:0] w_weight_sat;
    ictf_pkg::t_item w_item;
    ictf_pkg::t_feed w_feed;
    logic w_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= ictf_pkg::WEIGHT_RESET;
        end else if (i_cfg_valid) begin
            r_weight <= i_cfg_data;
        end
    end

    assign w_weight_sat = (r_weight > ictf_pkg::WEIGHT_ONE) ? ictf_pkg::WEIGHT_ONE : r_weight;

    always_comb begin
        w_item.accel_x   = $signed(i_accel_x);
        w_item.accel_y   = $signed(i_accel_y);
        w_item.accel_z   = $signed(i_accel_z);
        w_item.rate_x    = $signed(i_rate_x);
        w_item.rate_y    = $signed(i_rate_y);
        w_item.rate_z    = $signed(i_rate_z);
        w_item.time_step = i_time_step;
    end

    ictf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (w_item),
        .o_feed  (w_feed),
        .i_take  (w_take)
    );

    ictf_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_feed      (w_feed),
        .o_take      (w_take),
        .i_weight    (w_weight_sat),
        .empty       (empty),
        .pop         (pop),
        .o_roll_out  (o_roll_out),
        .o_pitch_out (o_pitch_out),
        .o_yaw_out   (o_yaw_out)
    );

endmodule
`default_nettype wire

// ----- sv/ictf_front.sv -----
// Input side of the tilt filter: a two-entry queue of sample beats.
// Depends on ictf_pkg for the item and feed types.
`timescale 1ns / 1ps
`default_nettype none
module ictf_front (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            push,
    output logic           full,
    input  wire ictf_pkg::t_item i_item,
    output ictf_pkg::t_feed o_feed,
    input  wire            i_take
);

    ictf_pkg::t_item r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       w_push, w_pop;

    assign full   = (r_count == 2'd2);
    assign w_push = push && !full;
    assign w_pop  = i_take && (r_count != 2'd0);

    assign o_feed.valid = (r_count != 2'd0);
    assign o_feed.item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

// ----- sv/ictf_back.sv -----
// Back end of the tilt filter: gyro integration, shared square root and CORDIC,
// blend and the output register. Depends on ictf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ictf_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire ictf_pkg::t_feed i_feed,
    output logic            o_take,
    input  wire [16:0]      i_weight,
    output logic            empty,
    input  wire             pop,
    output logic [31:0]     o_roll_out,
    output logic [31:0]     o_pitch_out,
    output logic [31:0]     o_yaw_out
);

    localparam logic [ictf_pkg::STEP_W-1:0] LAST_STEP = ictf_pkg::STEP_W'(CORDIC_STEPS - 1);
    localparam logic [ictf_pkg::STEP_W-1:0] LAST_SQRT =
        ictf_pkg::STEP_W'(ictf_pkg::SQRT_ITERS - 1);

    ictf_pkg::t_state r_state, n_state;
    ictf_pkg::t_item  r_item;

    logic signed [38:0] r_px, r_py, r_pz;
    logic [31:0] r_roll, r_pitch, r_yaw, r_groll, r_gpitch;
    logic        r_axis;
    logic signed [16:0] r_num;
    logic [31:0] r_sq_p, r_sq_q;
    logic [47:0] r_rad;
    logic [26:0] r_rem;
    logic [23:0] r_root;
    logic [ictf_pkg::STEP_W-1:0] r_cnt;
    logic signed [27:0] r_x, r_y;
    logic signed [25:0] r_z;
    logic signed [49:0] r_mg;
    logic signed [43:0] r_ma;
    logic        r_out_valid;
    logic [31:0] r_out_roll, r_out_pitch, r_out_yaw;

    logic        w_out_free;
    logic        w_load_out;
    logic signed [28:0] w_inc_x, w_inc_y, w_inc_z;
    logic [31:0] w_sum;
    logic [26:0] w_rem_try, w_trial;
    logic        w_fits;
    logic [23:0] w_root_next;
    logic signed [27:0] w_dx, w_dy;
    logic signed [15:0] w_p, w_q;
    logic signed [16:0] w_num;
    logic [31:0] w_gyro;
    logic signed [49:0] w_blend;

    assign w_out_free = !r_out_valid || pop;

    // Rounded gyro increments: (rate*dt + 512) >>> 10.
    assign w_inc_x = 29'((r_px + 39'sd512) >>> 10);
    assign w_inc_y = 29'((r_py + 39'sd512) >>> 10);
    assign w_inc_z = 29'((r_pz + 39'sd512) >>> 10);

    assign w_sum       = r_sq_p + r_sq_q;
    assign w_rem_try   = {r_rem[24:0], r_rad[47:46]};
    assign w_trial     = {1'b0, r_root, 2'b01};
    assign w_fits      = (w_rem_try >= w_trial);
    assign w_root_next = {r_root[22:0], w_fits};

    assign w_dx = r_y >>> r_cnt;
    assign w_dy = r_x >>> r_cnt;

    // Roll uses (ay; ax, az), pitch uses (-ax; ay, az).
    assign w_p   = r_axis ? r_item.accel_y : r_item.accel_x;
    assign w_q   = r_item.accel_z;
    assign w_num = r_axis ? -{r_item.accel_x[15], r_item.accel_x}
                          : {r_item.accel_y[15], r_item.accel_y};

    assign w_gyro  = r_axis ? r_gpitch : r_groll;
    assign w_blend = r_mg + 50'(r_ma) + 50'sd32768;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ictf_pkg::ST_IDLE:   if (i_feed.valid) n_state = ictf_pkg::ST_INC;
            ictf_pkg::ST_INC:    n_state = ictf_pkg::ST_GSUM;
            ictf_pkg::ST_GSUM:   n_state = ictf_pkg::ST_SQ;
            ictf_pkg::ST_SQ:     n_state = ictf_pkg::ST_SUM;
            ictf_pkg::ST_SUM:    n_state = (w_sum == 32'd0) ? ictf_pkg::ST_BMUL
                                                            : ictf_pkg::ST_SQRT;
            ictf_pkg::ST_SQRT:   if (r_cnt == LAST_SQRT) n_state = ictf_pkg::ST_CORDIC;
            ictf_pkg::ST_CORDIC: if (r_cnt == LAST_STEP) n_state = ictf_pkg::ST_BMUL;
            ictf_pkg::ST_BMUL:   n_state = ictf_pkg::ST_BADD;
            ictf_pkg::ST_BADD:   n_state = r_axis ? ictf_pkg::ST_OUT : ictf_pkg::ST_SQ;
            ictf_pkg::ST_OUT:    if (w_out_free) n_state = ictf_pkg::ST_IDLE;
            default:             n_state = ictf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_take     = (r_state == ictf_pkg::ST_IDLE) && i_feed.valid;
        w_load_out = (r_state == ictf_pkg::ST_OUT) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ictf_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_roll      <= 32'd0;
            r_pitch     <= 32'd0;
            r_yaw       <= 32'd0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ictf_pkg::ST_GSUM) begin
                r_yaw <= r_yaw + {{3{w_inc_z[28]}}, w_inc_z};
            end
            if (r_state == ictf_pkg::ST_BADD) begin
                if (r_axis) begin
                    r_pitch <= w_blend[47:16];
                end else begin
                    r_roll <= w_blend[47:16];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ictf_pkg::ST_IDLE: begin
                r_item <= i_feed.item;
                r_axis <= 1'b0;
            end
            ictf_pkg::ST_INC: begin
                r_px <= 39'(r_item.rate_x) * 39'($signed({1'b0, r_item.time_step}));
                r_py <= 39'(r_item.rate_y) * 39'($signed({1'b0, r_item.time_step}));
                r_pz <= 39'(r_item.rate_z) * 39'($signed({1'b0, r_item.time_step}));
            end
            ictf_pkg::ST_GSUM: begin
                r_groll  <= r_roll + {{3{w_inc_x[28]}}, w_inc_x};
                r_gpitch <= r_pitch + {{3{w_inc_y[28]}}, w_inc_y};
            end
            ictf_pkg::ST_SQ: begin
                r_sq_p <= 32'(w_p) * 32'(w_p);
                r_sq_q <= 32'(w_q) * 32'(w_q);
                r_num  <= w_num;
            end
            ictf_pkg::ST_SUM: begin
                r_rad  <= {w_sum, 16'h0000};
                r_rem  <= 27'd0;
                r_root <= 24'd0;
                r_cnt  <= '0;
                if (r_num > 17'sd0) begin
                    r_z <= ictf_pkg::NINETY_DEG;
                end else if (r_num < 17'sd0) begin
                    r_z <= -ictf_pkg::NINETY_DEG;
                end else begin
                    r_z <= 26'sd0;
                end
            end
            ictf_pkg::ST_SQRT: begin
                r_rem  <= w_fits ? (w_rem_try - w_trial) : w_rem_try;
                r_root <= w_root_next;
                r_rad  <= {r_rad[45:0], 2'b00};
                if (r_cnt == LAST_SQRT) begin
                    r_x   <= {4'b0000, w_root_next};
                    r_y   <= 28'(r_num) <<< 8;
                    r_z   <= 26'sd0;
                    r_cnt <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            ictf_pkg::ST_CORDIC: begin
                if (r_y >= 28'sd0) begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + ictf_pkg::atan_ang(r_cnt);
                end else begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - ictf_pkg::atan_ang(r_cnt);
                end
                r_cnt <= r_cnt + 1'b1;
            end
            ictf_pkg::ST_BMUL: begin
                r_mg <= $signed({1'b0, i_weight}) * $signed(w_gyro);
                r_ma <= 44'($signed({1'b0, ictf_pkg::WEIGHT_ONE - i_weight})) * 44'(r_z);
            end
            ictf_pkg::ST_BADD: begin
                r_axis <= 1'b1;
            end
            default: begin
            end
        endcase
        if (w_load_out) begin
            r_out_roll  <= r_roll;
            r_out_pitch <= r_pitch;
            r_out_yaw   <= r_yaw;
        end
    end

    assign empty       = !r_out_valid;
    assign o_roll_out  = r_out_roll;
    assign o_pitch_out = r_out_pitch;
    assign o_yaw_out   = r_out_yaw;

    a_sqrt_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ictf_pkg::ST_SQRT |-> r_cnt <= LAST_SQRT)
        else $error("square root step count out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ictf_pkg::ST_OUT && r_out_valid && !pop) |=> r_state == ictf_pkg::ST_OUT)
        else $error("result overwritten before it was taken");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> empty)
        else $error("result valid right after reset");

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |=> r_state == ictf_pkg::ST_INC)
        else $error("taken item did not start processing");

endmodule
`default_nettype wire
